FILE: hdl/wrf_pkg.sv
package wrf_pkg;

   localparam int WORD_MAX = 63;
   localparam int CNT_W = $clog2(WORD_MAX + 1);
   localparam int ADDR_W = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

   localparam int CHAR_W = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 1;

   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [CHAR_W-1:0] LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

   localparam logic [CSR_IDX_W-1:0] REG_UPPER_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE_MODE = 1'b1;

   localparam logic [1:0] OUT_NONE = 2'd0;
   localparam logic [1:0] OUT_PASS = 2'd1;
   localparam logic [1:0] OUT_SPACE = 2'd2;
   localparam logic [1:0] OUT_WORD = 2'd3;

   typedef struct packed {
      logic       store;
      logic       set_ovf;
      logic       clear_word;
      logic       load_ptr;
      logic       dec_ptr;
      logic       rd_en;
      logic [1:0] out_sel;
      logic       out_last;
   } wrf_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic is_eos;
      logic is_space;
      logic reverse;
      logic cnt_zero;
      logic cnt_full;
      logic ptr_zero;
      logic out_free;
   } wrf_status_type;

   function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c,
                                                  input logic en);
      logic [CHAR_W-1:0] r;
      r = c;
      if (en && (c >= LOWER_A) && (c <= LOWER_Z)) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

FILE: hdl/wrf_if.sv
interface wrf_req_if;
   logic                           valid;
   logic                           ready;
   logic [wrf_pkg::CHAR_W-1:0]     in_char;
   logic                           end_of_stream;

   modport source (output valid, output in_char, output end_of_stream, input ready);
   modport sink (input valid, input in_char, input end_of_stream, output ready);
endinterface

interface wrf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [wrf_pkg::CHAR_W-1:0]     out_char;
   logic                           last_of_run;
   logic                           overflowed;

   modport source (output valid, output out_char, output last_of_run, output overflowed,
                   input ready);
   modport sink (input valid, input out_char, input last_of_run, input overflowed,
                 output ready);
endinterface

FILE: hdl/wrf_ram.sv
module wrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/wrf_ctrl.sv
module wrf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  wrf_pkg::wrf_status_type status,
   output wrf_pkg::wrf_cmd_type    cmd,
   output logic                    req_ready
);

   localparam logic [1:0] S_RUN = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;
   localparam logic [1:0] S_SPACE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       add_space_ff, add_space_in;
   logic       accept;

   assign req_ready = (state_ff == S_RUN) && status.out_free;
   assign accept = req_ready && status.req_valid;

   always_comb begin
      state_in = state_ff;
      add_space_in = add_space_ff;
      cmd = '0;
      cmd.out_sel = wrf_pkg::OUT_NONE;
      unique case (state_ff)
         S_RUN: begin
            if (accept) begin
               if (status.is_eos) begin
                  if (status.reverse) begin
                     if (status.cnt_zero) begin
                        cmd.clear_word = 1'b1;
                     end else begin
                        cmd.load_ptr = 1'b1;
                        add_space_in = 1'b0;
                        state_in = S_FETCH;
                     end
                  end
               end else if (!status.reverse) begin
                  cmd.out_sel = wrf_pkg::OUT_PASS;
                  cmd.out_last = 1'b1;
               end else if (status.is_space) begin
                  if (status.cnt_zero) begin
                     cmd.out_sel = wrf_pkg::OUT_SPACE;
                     cmd.out_last = 1'b1;
                     cmd.clear_word = 1'b1;
                  end else begin
                     cmd.load_ptr = 1'b1;
                     add_space_in = 1'b1;
                     state_in = S_FETCH;
                  end
               end else if (status.cnt_full) begin
                  cmd.set_ovf = 1'b1;
               end else begin
                  cmd.store = 1'b1;
               end
            end
         end
         S_FETCH: begin
            cmd.rd_en = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (status.out_free) begin
               cmd.out_sel = wrf_pkg::OUT_WORD;
               cmd.out_last = status.ptr_zero && !add_space_ff;
               if (status.ptr_zero) begin
                  if (add_space_ff) begin
                     state_in = S_SPACE;
                  end else begin
                     cmd.clear_word = 1'b1;
                     state_in = S_RUN;
                  end
               end else begin
                  cmd.dec_ptr = 1'b1;
                  state_in = S_FETCH;
               end
            end
         end
         S_SPACE: begin
            if (status.out_free) begin
               cmd.out_sel = wrf_pkg::OUT_SPACE;
               cmd.out_last = 1'b1;
               cmd.clear_word = 1'b1;
               state_in = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
         add_space_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         add_space_ff <= add_space_in;
      end
   end

endmodule

FILE: hdl/wrf_datapath.sv
module wrf_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  wrf_pkg::wrf_cmd_type              cmd,
   output wrf_pkg::wrf_status_type           status,
   input  logic                              req_valid,
   input  logic [wrf_pkg::CHAR_W-1:0]        in_char,
   input  logic                              end_of_stream,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [wrf_pkg::CHAR_W-1:0]        out_char,
   output logic                              last_of_run,
   output logic                              overflowed,
   input  logic                              csr_wr_en,
   input  logic [wrf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wrf_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   logic                              upper_ff, upper_in;
   logic                              reverse_ff, reverse_in;
   logic [wrf_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic                              ovf_ff, ovf_in;
   logic [wrf_pkg::ADDR_W-1:0]        ptr_ff, ptr_in;
   logic                              out_valid_ff, out_valid_in;
   logic [wrf_pkg::CHAR_W-1:0]        out_char_ff, out_char_in;
   logic                              out_last_ff, out_last_in;
   logic                              out_ovf_ff, out_ovf_in;
   logic [wrf_pkg::CHAR_W-1:0]        in_upper;
   logic [wrf_pkg::CHAR_W-1:0]        rd_data;
   logic                              out_free;

   assign in_upper = wrf_pkg::to_upper(in_char, upper_ff);
   assign out_free = !out_valid_ff || rsp_ready;

   wrf_ram #(
      .WIDTH (wrf_pkg::CHAR_W),
      .DEPTH (wrf_pkg::WORD_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (cnt_ff[wrf_pkg::ADDR_W-1:0]),
      .wr_data (in_upper),
      .rd_en   (cmd.rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      upper_in = upper_ff;
      reverse_in = reverse_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            wrf_pkg::REG_UPPER_MODE: upper_in = csr_wr_data[0];
            wrf_pkg::REG_REVERSE_MODE: reverse_in = csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      ptr_in = ptr_ff;
      if (cmd.clear_word) begin
         cnt_in = '0;
         ovf_in = 1'b0;
      end else begin
         if (cmd.store) begin
            cnt_in = cnt_ff + wrf_pkg::CNT_W'(1);
         end
         if (cmd.set_ovf) begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.load_ptr) begin
         ptr_in = wrf_pkg::ADDR_W'(cnt_ff - wrf_pkg::CNT_W'(1));
      end else if (cmd.dec_ptr) begin
         ptr_in = ptr_ff - wrf_pkg::ADDR_W'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_char_in = out_char_ff;
      out_last_in = out_last_ff;
      out_ovf_in = out_ovf_ff;
      if (cmd.out_sel != wrf_pkg::OUT_NONE) begin
         out_valid_in = 1'b1;
         out_last_in = cmd.out_last;
         out_ovf_in = ovf_ff;
      end
      unique case (cmd.out_sel)
         wrf_pkg::OUT_PASS: begin
            out_char_in = in_upper;
            out_ovf_in = 1'b0;
         end
         wrf_pkg::OUT_SPACE: out_char_in = wrf_pkg::SPACE_CHAR;
         wrf_pkg::OUT_WORD: out_char_in = rd_data;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= 1'b0;
         reverse_ff <= 1'b0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         upper_ff <= upper_in;
         reverse_ff <= reverse_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_ovf_ff <= out_ovf_in;
   end

   always_comb begin
      status.req_valid = req_valid;
      status.is_eos = end_of_stream;
      status.is_space = (in_char == wrf_pkg::SPACE_CHAR);
      status.reverse = reverse_ff;
      status.cnt_zero = (cnt_ff == '0);
      status.cnt_full = (cnt_ff == wrf_pkg::CNT_W'(wrf_pkg::WORD_MAX));
      status.ptr_zero = (ptr_ff == '0);
      status.out_free = out_free;
   end

   assign rsp_valid = out_valid_ff;
   assign out_char = out_char_ff;
   assign last_of_run = out_last_ff;
   assign overflowed = out_ovf_ff;

endmodule

FILE: hdl/word_reverse_upper_filter.sv
// Byte-stream text filter. With reverse mode off every byte comes out once,
// optionally upper-cased, and the block takes one byte per cycle while the
// result side keeps up. With reverse mode on, word bytes go into a 63-entry
// word store at one per cycle while the result side keeps up and give no
// result (bytes past 63 are dropped and the word is marked overflowed); a
// space or end marker after a non-empty word then stalls the input while
// the word is sent back out last byte first, each byte taking a registered
// read of the store and then a load of the output register, followed by the
// trailing space after a space. An end marker with an empty store, or with
// reverse mode off, gives no result. The result beat that ends each input's
// run has last_of_run set.
module word_reverse_upper_filter (
   input  logic                           clock,
   input  logic                           reset,
   wrf_req_if.sink                        req_chan,
   wrf_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [wrf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wrf_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   wrf_pkg::wrf_cmd_type    cmd;
   wrf_pkg::wrf_status_type status;
   logic                    req_ready;

   wrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   wrf_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_valid     (req_chan.valid),
      .in_char       (req_chan.in_char),
      .end_of_stream (req_chan.end_of_stream),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .out_char      (rsp_chan.out_char),
      .last_of_run   (rsp_chan.last_of_run),
      .overflowed    (rsp_chan.overflowed),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   assign req_chan.ready = req_ready;

endmodule

FILE: hdl/wrf_checker.sv
module wrf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_eos,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_last,
   input logic                           rsp_ovf,
   input logic                           csr_wr_en,
   input logic [wrf_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [wrf_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   logic rev_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_mode_ff <= 1'b0;
      end else if (csr_wr_en && (csr_index == wrf_pkg::REG_REVERSE_MODE)) begin
         rev_mode_ff <= csr_wr_data[0];
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while a result beat is stalled");

   a_pass_beat: assert property (@(posedge clock) disable iff (reset)
      !rev_mode_ff && req_valid && req_ready && !req_eos |=>
         rsp_valid && rsp_last && !rsp_ovf)
      else $error("pass-through byte did not produce a single clean beat");

endmodule

bind word_reverse_upper_filter wrf_checker u_wrf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_eos     (req_chan.end_of_stream),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_last    (rsp_chan.last_of_run),
   .rsp_ovf     (rsp_chan.overflowed),
   .csr_wr_en   (csr_wr_en),
   .csr_index   (csr_index),
   .csr_wr_data (csr_wr_data)
);

FILE: verif/tb.sv
module tb;

   localparam int RANDOM_ITEMS = 240;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [wrf_pkg::CHAR_W-1:0] ch;
      logic                       eos;
   } text_item_type;

   typedef struct packed {
      logic [wrf_pkg::CHAR_W-1:0] ch;
      logic                       last;
      logic                       ovf;
   } text_beat_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_wr_en;
   logic [wrf_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [wrf_pkg::CSR_DATA_W-1:0] csr_wr_data;

   wrf_req_if req_chan ();
   wrf_rsp_if rsp_chan ();

   word_reverse_upper_filter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   text_item_type pending_items[$];
   text_beat_type expected_beats[$];

   logic [wrf_pkg::CHAR_W-1:0] word_buf [0:wrf_pkg::WORD_MAX-1];
   int         word_len = 0;
   logic       word_dropped = 1'b0;
   logic       upper_on = 1'b0;
   logic       reverse_on = 1'b0;

   int         fail_count = 0;
   int         random_items = 0;
   bit         no_gaps = 1'b0;
   int         gap_left = 0;
   int         stall_left = 0;
   int         quiet_cycles = 0;
   text_beat_type want_beat;
   text_beat_type got_beat;

   function automatic logic [wrf_pkg::CHAR_W-1:0] upcase(input logic [wrf_pkg::CHAR_W-1:0] c);
      if (upper_on && c >= wrf_pkg::LOWER_A && c <= wrf_pkg::LOWER_Z) begin
         return c - wrf_pkg::CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic logic [wrf_pkg::CHAR_W-1:0] word_char();
      logic [wrf_pkg::CHAR_W-1:0] c;
      if ($urandom_range(0, 9) < 6) begin
         c = wrf_pkg::CHAR_W'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
      end else begin
         c = wrf_pkg::CHAR_W'($urandom_range(0, 255));
         while (c == wrf_pkg::SPACE_CHAR) c = wrf_pkg::CHAR_W'($urandom_range(0, 255));
      end
      return c;
   endfunction

   // emit the stored word last byte first, plus a trailing space if asked, then clear it
   task automatic emit_word(input bit add_space);
      int total;
      int n;
      total = word_len + (add_space ? 1 : 0);
      n = 0;
      for (int k = word_len - 1; k >= 0; k--) begin
         n++;
         expected_beats.push_back('{word_buf[k], n == total, word_dropped});
      end
      if (add_space) begin
         expected_beats.push_back('{wrf_pkg::SPACE_CHAR, 1'b1, word_dropped});
      end
      word_len = 0;
      word_dropped = 1'b0;
   endtask

   task automatic model_text_byte(input logic [wrf_pkg::CHAR_W-1:0] c, input logic eos);
      if (eos) begin
         if (reverse_on) emit_word(1'b0);
      end else if (!reverse_on) begin
         expected_beats.push_back('{upcase(c), 1'b1, 1'b0});
      end else if (c == wrf_pkg::SPACE_CHAR) begin
         emit_word(1'b1);
      end else if (word_len < wrf_pkg::WORD_MAX) begin
         word_buf[word_len] = upcase(c);
         word_len++;
      end else begin
         word_dropped = 1'b1;
      end
   endtask

   task automatic queue_item(input logic [wrf_pkg::CHAR_W-1:0] c, input logic eos);
      pending_items.push_back('{c, eos});
      if (!eos || reverse_on) random_items++;
   endtask

   task automatic queue_word(input int len, input bit by_eos);
      for (int k = 0; k < len; k++) queue_item(word_char(), 1'b0);
      if (by_eos) begin
         queue_item(wrf_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1);
      end else begin
         queue_item(wrf_pkg::SPACE_CHAR, 1'b0);
      end
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || req_chan.valid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [wrf_pkg::CSR_IDX_W-1:0] idx, input logic val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == wrf_pkg::REG_UPPER_MODE) begin
         upper_on = val;
      end else begin
         reverse_on = val;
      end
   endtask

   task automatic set_modes(input logic upper, input logic reverse);
      drain();
      write_reg(wrf_pkg::REG_UPPER_MODE, upper);
      write_reg(wrf_pkg::REG_REVERSE_MODE, reverse);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.in_char = '0;
      req_chan.end_of_stream = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            model_text_byte(req_chan.in_char, req_chan.end_of_stream);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (!no_gaps && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(0, 5);
               req_chan.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_chan.in_char <= pending_items[0].ch;
               req_chan.end_of_stream <= pending_items[0].eos;
               req_chan.valid <= 1'b1;
               void'(pending_items.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_beat = '{rsp_chan.out_char, rsp_chan.last_of_run, rsp_chan.overflowed};
            if (expected_beats.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected beat char=%h last=%b ovf=%b", $time,
                        got_beat.ch, got_beat.last, got_beat.ovf);
            end else begin
               want_beat = expected_beats.pop_front();
               if (got_beat !== want_beat) begin
                  fail_count++;
                  $display("%0t: expected char=%h last=%b ovf=%b, got char=%h last=%b ovf=%b",
                           $time, want_beat.ch, want_beat.last, want_beat.ovf,
                           got_beat.ch, got_beat.last, got_beat.ovf);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!no_gaps && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int phase_end;
      int sel;
      int len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_modes(1'b0, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item(8'hFF, 1'b0);
      queue_item(8'h61, 1'b0);
      queue_item(8'h7A, 1'b0);
      queue_item(wrf_pkg::SPACE_CHAR, 1'b0);
      queue_item(8'h0A, 1'b0);
      queue_item(8'hA5, 1'b1);

      set_modes(1'b1, 1'b0);
      queue_item(8'h60, 1'b0);
      queue_item(8'h61, 1'b0);
      queue_item(8'h7A, 1'b0);
      queue_item(8'h7B, 1'b0);
      queue_item(8'h41, 1'b0);
      queue_item(8'hE1, 1'b0);

      set_modes(1'b1, 1'b1);
      queue_item(8'h61, 1'b0);
      queue_item(8'h62, 1'b0);
      queue_item(8'h0A, 1'b0);
      queue_item(wrf_pkg::SPACE_CHAR, 1'b0);
      queue_item(wrf_pkg::SPACE_CHAR, 1'b0);
      queue_item(wrf_pkg::SPACE_CHAR, 1'b1);
      queue_item(8'h68, 1'b0);
      queue_item(8'h69, 1'b0);
      queue_item(8'h00, 1'b1);
      queue_item(8'h78, 1'b0);
      queue_item(8'h79, 1'b0);

      // hold the pending word across a pass-through stretch
      set_modes(1'b0, 1'b0);
      queue_item(8'h71, 1'b0);
      queue_item(8'hFF, 1'b1);
      set_modes(1'b0, 1'b1);
      queue_item(wrf_pkg::SPACE_CHAR, 1'b0);
      queue_word(wrf_pkg::WORD_MAX, 1'b1);
      queue_word(wrf_pkg::WORD_MAX + 1, 1'b0);
      queue_word(wrf_pkg::WORD_MAX + 7, 1'b1);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items > RANDOM_ITEMS - 90) no_gaps = 1'b1;
         set_modes(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
         phase_end = random_items + $urandom_range(20, 60);
         while (random_items < phase_end) begin
            if (reverse_on && $urandom_range(0, 9) < 8) begin
               sel = $urandom_range(0, 49);
               if (sel == 0) begin
                  len = $urandom_range(56, 72);
               end else if (sel == 1) begin
                  len = $urandom_range(wrf_pkg::WORD_MAX - 1, wrf_pkg::WORD_MAX + 1);
               end else begin
                  len = $urandom_range(0, 8);
               end
               queue_word(len, $urandom_range(0, 4) == 0);
            end else begin
               queue_item(wrf_pkg::CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
